// ----- hdl/watm_pkg.sv -----
// ============================================================================
// Weekly alarm table matcher package
// Shared types, constants and codes for the weekly alarm table matcher.
// ============================================================================
package watm_pkg;

    localparam int MaxEntries = 16;
    localparam int SlotW      = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
    localparam int CountW     = $clog2(MaxEntries + 1);
    localparam int SlotFieldW = 4;
    localparam int CmpW       = (CountW > SlotFieldW) ? CountW : SlotFieldW;

    localparam logic [2:0] OpTick   = 3'd0;
    localparam logic [2:0] OpUpdate = 3'd1;
    localparam logic [2:0] OpDelete = 3'd2;
    localparam logic [2:0] OpStop   = 3'd3;
    localparam logic [2:0] OpRead   = 3'd4;

    localparam logic [1:0] StatusOk       = 2'd0;
    localparam logic [1:0] StatusBadIndex = 2'd1;
    localparam logic [1:0] StatusBadTime  = 2'd2;

    localparam logic [4:0] HourMax    = 5'd23;
    localparam logic [5:0] MinuteMax  = 6'd59;
    localparam logic [7:0] EmptyField = 8'hFF;
    localparam logic [2:0] NoDay      = 3'd7;

    typedef struct packed {
        logic [2:0] opcode;
        logic [3:0] slot;
        logic [4:0] hour_value;
        logic [5:0] minute_value;
        logic [6:0] day_mask;
        logic       enable_bit;
        logic [2:0] weekday;
        logic       time_valid;
    } t_request;

    typedef struct packed {
        logic [1:0] status;
        logic       fired;
        logic [3:0] fired_slot;
        logic       ringing;
        logic [4:0] entry_count;
        logic [7:0] read_hour;
        logic [7:0] read_minute;
        logic [7:0] read_days;
        logic       read_enabled;
        logic       read_fired_today;
    } t_result;

    typedef struct packed {
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] days;
        logic       enabled;
        logic       fired_today;
    } t_entry;

    localparam t_entry EmptyEntry = '{
        hour:        EmptyField,
        minute:      EmptyField,
        days:        EmptyField,
        enabled:     1'b0,
        fired_today: 1'b0
    };

    typedef struct packed {
        logic             wr_en;
        logic             clr_fired;
        logic [SlotW-1:0] wr_addr;
        t_entry           wr_data;
    } t_tbl_ctl;

endpackage

// ----- hdl/watm_table.sv -----
// ============================================================================
// Alarm table
// Register file of alarm entries with one read port, one write port and a
// bulk clear of the fired-today marks.
// ============================================================================
module watm_table (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  watm_pkg::t_tbl_ctl             i_ctl,
    input  logic [watm_pkg::SlotW-1:0]     i_rd_addr,
    output watm_pkg::t_entry               o_rd_data
);

    watm_pkg::t_entry r_mem [watm_pkg::MaxEntries];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < watm_pkg::MaxEntries; k++) begin
                r_mem[k] <= watm_pkg::EmptyEntry;
            end
        end else begin
            if (i_ctl.clr_fired) begin
                for (int k = 0; k < watm_pkg::MaxEntries; k++) begin
                    r_mem[k].fired_today <= 1'b0;
                end
            end
            if (i_ctl.wr_en) begin
                r_mem[i_ctl.wr_addr] <= i_ctl.wr_data;
            end
        end
    end

    assign o_rd_data = r_mem[i_rd_addr];

endmodule

// ----- hdl/watm_match.sv -----
// ============================================================================
// Alarm match comparator
// Compares one stored entry against the current weekday, hour and minute.
// ============================================================================
module watm_match (
    input  watm_pkg::t_entry i_entry,
    input  logic [4:0]       i_hour,
    input  logic [5:0]       i_minute,
    input  logic [2:0]       i_weekday,
    output logic             o_match
);

    logic day_hit;

    assign day_hit = (i_weekday != watm_pkg::NoDay) && i_entry.days[i_weekday];

    assign o_match = i_entry.enabled && !i_entry.fired_today && day_hit
                     && (i_entry.hour == {3'b000, i_hour})
                     && (i_entry.minute == {2'b00, i_minute});

endmodule

// ----- hdl/weekly_alarm_table_matcher_unit.sv -----
// ============================================================================
// Weekly alarm table matcher
// Sequencer that runs ticks, updates, deletes, stop and read requests against
// a table of weekly alarms through one shared comparator.
// ============================================================================
// A request is taken when start is high and busy is low; busy then stays high
// until the result has been built. Exactly one result follows each request,
// shown for one cycle with o_strobe, and the receiver cannot stall it. Stop,
// update, read and unsynced ticks pass from the check state straight to done.
// A tick scans the table one entry per cycle through the single comparator.
// A delete moves one entry per cycle through the single table port.
// The table is cleared by reset in the same cycle.
module weekly_alarm_table_matcher_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  watm_pkg::t_request  i_request,
    output logic                busy,
    output logic                o_strobe,
    output watm_pkg::t_result   o_result
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_SCAN  = 5'b00100,
        S_SHIFT = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                         r_state, n_state;
    watm_pkg::t_request             r_req, n_req;
    logic [watm_pkg::CountW-1:0]    r_idx, n_idx;
    logic [watm_pkg::CountW-1:0]    r_count, n_count;
    logic [2:0]                     r_last_day, n_last_day;
    logic                           r_ring, n_ring;
    logic [1:0]                     r_status, n_status;
    logic                           r_fired, n_fired;
    logic [watm_pkg::CountW-1:0]    r_fslot, n_fslot;
    watm_pkg::t_entry               r_rd, n_rd;
    logic                           r_strobe, n_strobe;
    watm_pkg::t_result              r_result, n_result;

    watm_pkg::t_tbl_ctl             tbl_ctl;
    logic [watm_pkg::SlotW-1:0]     rd_addr;
    watm_pkg::t_entry               rd_data;
    logic                           hit;
    logic [watm_pkg::CmpW-1:0]      slot_ext;
    logic [watm_pkg::CmpW-1:0]      count_ext;
    logic [watm_pkg::CountW-1:0]    idx_next;
    watm_pkg::t_entry               upd_entry;
    watm_pkg::t_entry               fire_entry;

    watm_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (tbl_ctl),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    watm_match u_match (
        .i_entry   (rd_data),
        .i_hour    (r_req.hour_value),
        .i_minute  (r_req.minute_value),
        .i_weekday (r_req.weekday),
        .o_match   (hit)
    );

    assign slot_ext  = watm_pkg::CmpW'(r_req.slot);
    assign count_ext = watm_pkg::CmpW'(r_count);
    assign idx_next  = r_idx + 1'b1;

    always_comb begin
        upd_entry             = watm_pkg::EmptyEntry;
        upd_entry.hour        = {3'b000, r_req.hour_value};
        upd_entry.minute      = {2'b00, r_req.minute_value};
        upd_entry.days        = {1'b0, r_req.day_mask};
        upd_entry.enabled     = r_req.enable_bit;
        upd_entry.fired_today = 1'b0;
        fire_entry             = rd_data;
        fire_entry.fired_today = 1'b1;
    end

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_idx      = r_idx;
        n_count    = r_count;
        n_last_day = r_last_day;
        n_ring     = r_ring;
        n_status   = r_status;
        n_fired    = r_fired;
        n_fslot    = r_fslot;
        n_rd       = r_rd;
        n_strobe   = 1'b0;
        n_result   = r_result;
        tbl_ctl    = '0;
        rd_addr    = r_idx[watm_pkg::SlotW-1:0];

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req    = i_request;
                    n_status = watm_pkg::StatusOk;
                    n_fired  = 1'b0;
                    n_fslot  = '0;
                    n_rd     = '0;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_DONE;
                case (r_req.opcode)
                    watm_pkg::OpTick: begin
                        if (r_req.time_valid) begin
                            if (r_last_day != r_req.weekday) begin
                                tbl_ctl.clr_fired = 1'b1;
                                n_last_day        = r_req.weekday;
                            end
                            n_idx   = '0;
                            n_state = S_SCAN;
                        end
                    end
                    watm_pkg::OpUpdate: begin
                        if (slot_ext >= watm_pkg::CmpW'(watm_pkg::MaxEntries)) begin
                            n_status = watm_pkg::StatusBadIndex;
                        end else if (r_req.hour_value > watm_pkg::HourMax
                                     || r_req.minute_value > watm_pkg::MinuteMax) begin
                            n_status = watm_pkg::StatusBadTime;
                        end else begin
                            tbl_ctl.wr_en   = 1'b1;
                            tbl_ctl.wr_addr = slot_ext[watm_pkg::SlotW-1:0];
                            tbl_ctl.wr_data = upd_entry;
                            if (slot_ext >= count_ext) begin
                                n_count = watm_pkg::CountW'(slot_ext + 1'b1);
                            end
                        end
                    end
                    watm_pkg::OpDelete: begin
                        if (slot_ext >= count_ext) begin
                            n_status = watm_pkg::StatusBadIndex;
                        end else begin
                            n_idx   = watm_pkg::CountW'(slot_ext);
                            n_state = S_SHIFT;
                        end
                    end
                    watm_pkg::OpStop: begin
                        n_ring = 1'b0;
                    end
                    watm_pkg::OpRead: begin
                        if (slot_ext >= count_ext) begin
                            n_status = watm_pkg::StatusBadIndex;
                            n_rd     = watm_pkg::EmptyEntry;
                        end else begin
                            rd_addr = slot_ext[watm_pkg::SlotW-1:0];
                            n_rd    = rd_data;
                        end
                    end
                    default: begin
                        n_status = watm_pkg::StatusOk;
                    end
                endcase
            end
            S_SCAN: begin
                if (r_ring || r_idx >= r_count) begin
                    n_state = S_DONE;
                end else if (hit) begin
                    tbl_ctl.wr_en   = 1'b1;
                    tbl_ctl.wr_addr = r_idx[watm_pkg::SlotW-1:0];
                    tbl_ctl.wr_data = fire_entry;
                    n_ring          = 1'b1;
                    n_fired         = 1'b1;
                    n_fslot         = r_idx;
                    n_state         = S_DONE;
                end else begin
                    n_idx = idx_next;
                end
            end
            S_SHIFT: begin
                tbl_ctl.wr_en   = 1'b1;
                tbl_ctl.wr_addr = r_idx[watm_pkg::SlotW-1:0];
                if (idx_next < r_count) begin
                    rd_addr         = idx_next[watm_pkg::SlotW-1:0];
                    tbl_ctl.wr_data = rd_data;
                    n_idx           = idx_next;
                end else begin
                    tbl_ctl.wr_data = watm_pkg::EmptyEntry;
                    n_count         = r_count - 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                n_result.status           = r_status;
                n_result.fired            = r_fired;
                n_result.fired_slot       = 4'(r_fslot);
                n_result.ringing          = r_ring;
                n_result.entry_count      = 5'(r_count);
                n_result.read_hour        = r_rd.hour;
                n_result.read_minute      = r_rd.minute;
                n_result.read_days        = r_rd.days;
                n_result.read_enabled     = r_rd.enabled;
                n_result.read_fired_today = r_rd.fired_today;
                n_strobe                  = 1'b1;
                n_state                   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_last_day <= watm_pkg::NoDay;
            r_ring     <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_last_day <= n_last_day;
            r_ring     <= n_ring;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_fired  <= n_fired;
        r_fslot  <= n_fslot;
        r_rd     <= n_rd;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

`ifndef ASSERT_OFF
    a_strobe_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_DONE))
        else $error("result strobe without a finished request");

    a_fired_rings: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.fired) |-> o_result.ringing)
        else $error("alarm fired without ringing flag");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= watm_pkg::CountW'(watm_pkg::MaxEntries))
        else $error("entry count beyond table depth");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");
`endif

endmodule
